FILE: src/tkpf_pkg.sv
package tkpf_pkg;

    // Default build values
    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int DEF_TOP_K       = 5;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths of the ports
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 11;
    localparam int CNT_W     = 3;
    localparam int OUT_SLOTS = 5;

    // Index reported for an empty slot
    localparam logic signed [IDX_W-1:0] EMPTY_IDX = '1;

endpackage

FILE: src/tkpf_window.sv
module tkpf_window
    import tkpf_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int HEIGHT_W   = DEF_SAMPLE_BITS,
    parameter int POS_W      = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_advance,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last,
    output logic                o_cand_valid,
    output logic [HEIGHT_W-1:0] o_cand_height,
    output logic [POS_W-1:0]    o_cand_pos,
    output logic                o_cand_last
);

    localparam int POSCNT_W = $clog2(MAX_WINDOW + 1);

    logic [HEIGHT_W-1:0] r_older;
    logic [HEIGHT_W-1:0] r_newer;
    logic [POSCNT_W-1:0] r_position;
    logic                r_cand_valid;
    logic                r_cand_last;
    logic [HEIGHT_W-1:0] r_cand_height;
    logic [POS_W-1:0]    r_cand_pos;

    logic [HEIGHT_W-1:0] s;
    logic                in_range;
    logic                peak;

    // Mask the sample and test the middle sample against both neighbors
    assign s        = i_sample[HEIGHT_W-1:0];
    assign in_range = r_position < POSCNT_W'(MAX_WINDOW);
    assign peak     = in_range && (r_position >= POSCNT_W'(2)) &&
                      (r_older < r_newer) && (r_newer > s);

    // Advance the sample window; drop it after the last transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older      <= '0;
            r_newer      <= '0;
            r_position   <= '0;
            r_cand_valid <= 1'b0;
            r_cand_last  <= 1'b0;
        end else begin
            if (i_advance) begin
                r_cand_valid <= i_accept && peak;
                r_cand_last  <= i_accept && i_last;
            end
            if (i_accept) begin
                if (i_last) begin
                    r_older    <= '0;
                    r_newer    <= '0;
                    r_position <= '0;
                end else if (in_range) begin
                    r_older    <= r_newer;
                    r_newer    <= s;
                    r_position <= r_position + POSCNT_W'(1);
                end
            end
        end
    end

    // Hold the candidate peak for the slot chain
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_cand_height <= r_newer;
            r_cand_pos    <= POS_W'(r_position - POSCNT_W'(1));
        end
    end

    assign o_cand_valid  = r_cand_valid;
    assign o_cand_height = r_cand_height;
    assign o_cand_pos    = r_cand_pos;
    assign o_cand_last   = r_cand_last;

endmodule

FILE: src/tkpf_cell.sv
module tkpf_cell
    import tkpf_pkg::*;
#(
    parameter int HEIGHT_W = DEF_SAMPLE_BITS,
    parameter int POS_W    = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_clear,
    input  logic                i_cand_valid,
    input  logic [HEIGHT_W-1:0] i_cand_height,
    input  logic [POS_W-1:0]    i_cand_pos,
    input  logic                i_prev_valid,
    input  logic [HEIGHT_W-1:0] i_prev_height,
    input  logic [POS_W-1:0]    i_prev_pos,
    input  logic                i_prev_take,
    output logic                o_valid,
    output logic [HEIGHT_W-1:0] o_height,
    output logic [POS_W-1:0]    o_pos,
    output logic                o_take,
    output logic                o_next_valid,
    output logic [POS_W-1:0]    o_next_pos
);

    logic                r_valid;
    logic [HEIGHT_W-1:0] r_height;
    logic [POS_W-1:0]    r_pos;
    logic                n_valid;
    logic [HEIGHT_W-1:0] n_height;
    logic [POS_W-1:0]    n_pos;
    logic                take;

    // A strictly taller candidate, or an empty slot, displaces this slot;
    // equal heights keep the older peak in front
    assign take = i_cand_valid && (!r_valid || (i_cand_height > r_height));

    // Shift from the neighbor when it was displaced too, else load candidate
    always_comb begin
        n_valid  = r_valid;
        n_height = r_height;
        n_pos    = r_pos;
        if (take) begin
            if (i_prev_take) begin
                n_valid  = i_prev_valid;
                n_height = i_prev_height;
                n_pos    = i_prev_pos;
            end else begin
                n_valid  = 1'b1;
                n_height = i_cand_height;
                n_pos    = i_cand_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_clear ? 1'b0 : n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_height <= n_height;
            r_pos    <= n_pos;
        end
    end

    assign o_valid      = r_valid;
    assign o_height     = r_height;
    assign o_pos        = r_pos;
    assign o_take       = take;
    assign o_next_valid = n_valid;
    assign o_next_pos   = n_pos;

endmodule

FILE: src/top_k_local_peak_finder.sv
// A result passes the window's last-flag register and then the output register
// after the transfer of the last sample; a stall can hold it between the two.
// Throughput: one sample per cycle; the input stalls only while a finished
// result waits in the output register and the next window end has reached
// the slot chain.
// Reset: synchronous, active low; clears the sample window, the slot valid
// bits and the output valid flag.
module top_k_local_peak_finder
    import tkpf_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int TOP_K       = DEF_TOP_K,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_W-1:0]     i_sample,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [IDX_W-1:0] o_peak_index_0,
    output logic signed [IDX_W-1:0] o_peak_index_1,
    output logic signed [IDX_W-1:0] o_peak_index_2,
    output logic signed [IDX_W-1:0] o_peak_index_3,
    output logic signed [IDX_W-1:0] o_peak_index_4,
    output logic [CNT_W-1:0]        o_peak_count
);

    localparam int HEIGHT_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int POS_W    = $clog2(MAX_WINDOW);
    localparam int NUM_REP  = (TOP_K < OUT_SLOTS) ? TOP_K : OUT_SLOTS;

    logic                accept;
    logic                advance;
    logic                stall;
    logic                clear;
    logic                load;

    logic                cand_valid;
    logic [HEIGHT_W-1:0] cand_height;
    logic [POS_W-1:0]    cand_pos;
    logic                cand_last;

    logic                c_valid      [TOP_K];
    logic [HEIGHT_W-1:0] c_height     [TOP_K];
    logic [POS_W-1:0]    c_pos        [TOP_K];
    logic                c_take       [TOP_K];
    logic                c_next_valid [TOP_K];
    logic [POS_W-1:0]    c_next_pos   [TOP_K];

    logic                    r_o_valid;
    logic signed [IDX_W-1:0] r_o_idx [OUT_SLOTS];
    logic [CNT_W-1:0]        r_o_count;
    logic signed [IDX_W-1:0] n_idx   [OUT_SLOTS];
    logic [CNT_W-1:0]        n_count;

    // Hold the chain while a window end cannot reach the output register
    assign stall   = cand_last && r_o_valid && !i_ready;
    assign advance = !stall;
    assign o_ready = advance;
    assign accept  = i_valid && o_ready;
    assign clear   = cand_last;
    assign load    = cand_last && advance;

    tkpf_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .HEIGHT_W   (HEIGHT_W),
        .POS_W      (POS_W)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_advance     (advance),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .o_cand_valid  (cand_valid),
        .o_cand_height (cand_height),
        .o_cand_pos    (cand_pos),
        .o_cand_last   (cand_last)
    );

    // Row of slot cells, tallest first
    for (genvar k = 0; k < TOP_K; k++) begin : g_cell
        logic                prev_valid;
        logic [HEIGHT_W-1:0] prev_height;
        logic [POS_W-1:0]    prev_pos;
        logic                prev_take;

        if (k == 0) begin : g_head
            assign prev_valid  = 1'b0;
            assign prev_height = '0;
            assign prev_pos    = '0;
            assign prev_take   = 1'b0;
        end else begin : g_link
            assign prev_valid  = c_valid[k-1];
            assign prev_height = c_height[k-1];
            assign prev_pos    = c_pos[k-1];
            assign prev_take   = c_take[k-1];
        end

        tkpf_cell #(
            .HEIGHT_W (HEIGHT_W),
            .POS_W    (POS_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_advance     (advance),
            .i_clear       (clear),
            .i_cand_valid  (cand_valid),
            .i_cand_height (cand_height),
            .i_cand_pos    (cand_pos),
            .i_prev_valid  (prev_valid),
            .i_prev_height (prev_height),
            .i_prev_pos    (prev_pos),
            .i_prev_take   (prev_take),
            .o_valid       (c_valid[k]),
            .o_height      (c_height[k]),
            .o_pos         (c_pos[k]),
            .o_take        (c_take[k]),
            .o_next_valid  (c_next_valid[k]),
            .o_next_pos    (c_next_pos[k])
        );
    end

    // Map the updated slots onto the report fields
    for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_rep
        if (s < TOP_K) begin : g_used
            assign n_idx[s] = c_next_valid[s] ? IDX_W'(c_next_pos[s]) : EMPTY_IDX;
        end else begin : g_empty
            assign n_idx[s] = EMPTY_IDX;
        end
    end

    // Count filled slots among the reported ones
    always_comb begin
        n_count = '0;
        for (int s = 0; s < NUM_REP; s++) begin
            if (c_next_valid[s]) begin
                n_count = n_count + CNT_W'(1);
            end
        end
    end

    // Output register: load on a window end, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_idx   <= n_idx;
            r_o_count <= n_count;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_peak_index_0 = r_o_idx[0];
    assign o_peak_index_1 = r_o_idx[1];
    assign o_peak_index_2 = r_o_idx[2];
    assign o_peak_index_3 = r_o_idx[3];
    assign o_peak_index_4 = r_o_idx[4];
    assign o_peak_count   = r_o_count;

endmodule

FILE: src/tkpf_checker.sv
module tkpf_checker
    import tkpf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic [SAMPLE_W-1:0]     i_sample,
    input logic                    i_last,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic signed [IDX_W-1:0] o_peak_index_0,
    input logic signed [IDX_W-1:0] o_peak_index_1,
    input logic signed [IDX_W-1:0] o_peak_index_2,
    input logic signed [IDX_W-1:0] o_peak_index_3,
    input logic signed [IDX_W-1:0] o_peak_index_4,
    input logic [CNT_W-1:0]        o_peak_count
);

    // Hold a result that is not taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_peak_count) &&
        $stable(o_peak_index_0) && $stable(o_peak_index_4))
        else $error("result changed while stalled");

    // A new result must follow a last-sample transfer
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_last, 2))
        else $error("result without a window end");

    // Input backpressure only while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a waiting result");

    // Count agrees with the first and last reported slots
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_count <= CNT_W'(OUT_SLOTS)) &&
        ((o_peak_index_0 != EMPTY_IDX) == (o_peak_count != '0)))
        else $error("count does not match first slot");

    a_fifth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_peak_index_4 != EMPTY_IDX) == (o_peak_count == CNT_W'(OUT_SLOTS))))
        else $error("count does not match fifth slot");

endmodule

bind top_k_local_peak_finder tkpf_checker u_tkpf_checker (.*);
